// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the circle rasterizer RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define CRZ_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define CRZ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/crz_pkg.sv =====
// Shared types, constants and the primitive generator of the circle rasterizer.
// No dependencies; used by all crz modules and the core top level.
package crz_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int COORD_W     = 15;
    localparam int RADIUS_W    = 14;
    localparam int DEC_W       = 17;
    localparam int OUT_W       = 16;
    localparam int IDX_W       = 3;

    // Command codes carried in the input tuser field.
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // Index of the final primitive of a step for each kind of step.
    localparam logic [IDX_W-1:0] LAST_OUTLINE = 3'd7;
    localparam logic [IDX_W-1:0] LAST_FILL    = 3'd3;
    localparam logic [IDX_W-1:0] LAST_IDLE    = 3'd0;

    // Snapshot of one step, handed from the front to the back.
    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic        [COORD_W-1:0] ox;
        logic signed [COORD_W-1:0] oy;
        logic                      fill;
        logic                      live;
        logic                      done;
    } t_step;

    // One result word.
    typedef struct packed {
        logic signed [OUT_W-1:0] x_start;
        logic signed [OUT_W-1:0] x_end;
        logic signed [OUT_W-1:0] row_y;
        logic                    prim_valid;
        logic                    last;
        logic                    done;
    } t_prim;

    // Builds primitive number idx of a step.
    // Outline: bit 0 swaps the offsets, bit 1 negates the column offset,
    // bit 2 negates the row offset. Fill: the middle two spans use the
    // column offset for the width, and bit 1 negates the row offset.
    function automatic t_prim prim_of(t_step s, logic [IDX_W-1:0] idx);
        logic signed [OUT_W:0] cx_w;
        logic signed [OUT_W:0] cy_w;
        logic signed [OUT_W:0] ox_w;
        logic signed [OUT_W:0] oy_w;
        logic signed [OUT_W:0] xoff;
        logic signed [OUT_W:0] yoff;
        logic signed [OUT_W:0] xs;
        logic signed [OUT_W:0] xe;
        logic signed [OUT_W:0] ry;
        logic                  swap;
        logic [IDX_W-1:0]      last_idx;
        t_prim                 p;
        cx_w = {{2{s.cx[COORD_W-1]}}, s.cx};
        cy_w = {{2{s.cy[COORD_W-1]}}, s.cy};
        ox_w = {2'b00, s.ox};
        oy_w = {{2{s.oy[COORD_W-1]}}, s.oy};
        if (s.fill) begin
            swap     = ~(idx[0] ^ idx[1]);
            last_idx = LAST_FILL;
        end else begin
            swap     = idx[0];
            last_idx = LAST_OUTLINE;
        end
        xoff = swap ? oy_w : ox_w;
        yoff = swap ? ox_w : oy_w;
        if (s.fill) begin
            xs = cx_w - xoff;
            xe = cx_w + xoff;
            ry = idx[1] ? (cy_w - yoff) : (cy_w + yoff);
        end else begin
            xs = idx[1] ? (cx_w - xoff) : (cx_w + xoff);
            xe = xs;
            ry = idx[2] ? (cy_w - yoff) : (cy_w + yoff);
        end
        if (s.live) begin
            p.x_start    = xs[OUT_W-1:0];
            p.x_end      = xe[OUT_W-1:0];
            p.row_y      = ry[OUT_W-1:0];
            p.prim_valid = 1'b1;
            p.last       = (idx == last_idx);
        end else begin
            p.x_start    = '0;
            p.x_end      = '0;
            p.row_y      = '0;
            p.prim_valid = 1'b0;
            p.last       = (idx == LAST_IDLE);
        end
        p.done = s.done;
        return p;
    endfunction

endpackage

// ===== rtl/core/crz_front.sv =====
// Front end of the circle rasterizer: command intake, circle state and the
// decision-variable update. Depends on crz_pkg; feeds crz_queue.
module crz_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_fill,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_command,
    input  logic signed [crz_pkg::COORD_W-1:0]  i_center_x,
    input  logic signed [crz_pkg::COORD_W-1:0]  i_center_y,
    input  logic        [crz_pkg::RADIUS_W-1:0] i_radius,
    input  logic                                i_q_full,
    output logic                                o_push,
    output crz_pkg::t_step                      o_entry
);

    localparam int W = crz_pkg::DEC_W + 3;

    logic                                r_fill;
    logic                                r_active;
    logic signed [crz_pkg::COORD_W-1:0]  r_cx;
    logic signed [crz_pkg::COORD_W-1:0]  r_cy;
    logic        [crz_pkg::RADIUS_W-1:0] r_radius;
    logic        [crz_pkg::COORD_W-1:0]  r_ox;
    logic signed [crz_pkg::COORD_W-1:0]  r_oy;
    logic signed [crz_pkg::DEC_W-1:0]    r_dec;

    logic                                n_active;
    logic        [crz_pkg::COORD_W-1:0]  n_ox;
    logic signed [crz_pkg::COORD_W-1:0]  n_oy;
    logic signed [crz_pkg::DEC_W-1:0]    n_dec;

    logic signed [W-1:0] d_w, ox_w, oy_w, r_w, lim_w, dn_w, oxn_w, oyn_w;
    logic accept;
    logic is_start;

    assign o_in_ready = ~i_q_full;
    assign accept     = i_in_valid & o_in_ready;
    assign is_start   = (i_command == crz_pkg::CMD_START);

    // Andres update: move right, move down, or move diagonally.
    always_comb begin
        d_w   = {{(W-crz_pkg::DEC_W){r_dec[crz_pkg::DEC_W-1]}}, r_dec};
        ox_w  = {{(W-crz_pkg::COORD_W){1'b0}}, r_ox};
        oy_w  = {{(W-crz_pkg::COORD_W){r_oy[crz_pkg::COORD_W-1]}}, r_oy};
        r_w   = {{(W-crz_pkg::RADIUS_W){1'b0}}, r_radius};
        lim_w = (r_w - oy_w) + (r_w - oy_w);
        if (d_w >= ox_w + ox_w) begin
            dn_w  = d_w - (ox_w + ox_w) - W'(1);
            oxn_w = ox_w + W'(1);
            oyn_w = oy_w;
        end else if (d_w < lim_w) begin
            dn_w  = d_w + (oy_w + oy_w) - W'(1);
            oxn_w = ox_w;
            oyn_w = oy_w - W'(1);
        end else begin
            dn_w  = d_w + (oy_w - ox_w - W'(1)) + (oy_w - ox_w - W'(1));
            oxn_w = ox_w + W'(1);
            oyn_w = oy_w - W'(1);
        end
        n_dec    = dn_w[crz_pkg::DEC_W-1:0];
        n_ox     = oxn_w[crz_pkg::COORD_W-1:0];
        n_oy     = oyn_w[crz_pkg::COORD_W-1:0];
        n_active = $signed({n_oy[crz_pkg::COORD_W-1], n_oy}) >= $signed({1'b0, n_ox});
    end

    // Snapshot of the current iteration for the back end.
    always_comb begin
        o_push        = accept & ~is_start;
        o_entry.cx    = r_cx;
        o_entry.cy    = r_cy;
        o_entry.ox    = r_ox;
        o_entry.oy    = r_oy;
        o_entry.fill  = r_fill;
        o_entry.live  = r_active;
        o_entry.done  = r_active ? ~n_active : 1'b1;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= 1'b0;
            r_active <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_fill <= i_cfg_fill;
            end
            if (accept) begin
                if (is_start) begin
                    r_active <= 1'b1;
                end else if (r_active) begin
                    r_active <= n_active;
                end
            end
        end
    end

    // Circle geometry and decision variable.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx     <= '0;
            r_cy     <= '0;
            r_radius <= '0;
            r_ox     <= '0;
            r_oy     <= '0;
            r_dec    <= '0;
        end else if (accept) begin
            if (is_start) begin
                r_cx     <= i_center_x;
                r_cy     <= i_center_y;
                r_radius <= i_radius;
                r_ox     <= '0;
                r_oy     <= {1'b0, i_radius};
                r_dec    <= {3'b000, i_radius} - crz_pkg::DEC_W'(1);
            end else if (r_active) begin
                r_ox  <= n_ox;
                r_oy  <= n_oy;
                r_dec <= n_dec;
            end
        end
    end

endmodule

// ===== rtl/core/crz_queue.sv =====
// Short queue of step snapshots between the front and the back end.
// Depends on crz_pkg for the entry type.
module crz_queue #(
    parameter int DEPTH = crz_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  crz_pkg::t_step i_entry,
    input  logic           i_pop,
    output crz_pkg::t_step o_head,
    output logic           o_valid,
    output logic           o_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    crz_pkg::t_step   r_slots [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_head  = r_slots[r_rd_ptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// ===== rtl/core/crz_back.sv =====
// Back end of the circle rasterizer: walks each queued step and emits its
// primitives into the output register. Depends on crz_pkg.
module crz_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  crz_pkg::t_step i_head,
    input  logic           i_head_valid,
    output logic           o_pop,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    output crz_pkg::t_prim o_out
);

    logic [crz_pkg::IDX_W-1:0] r_idx;
    logic                      r_out_valid;
    crz_pkg::t_prim            r_out;
    crz_pkg::t_prim            prim;
    logic                      load;

    assign prim        = crz_pkg::prim_of(i_head, r_idx);
    assign load        = i_head_valid & (~r_out_valid | i_out_ready);
    assign o_pop       = load & prim.last;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Primitive counter and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx       <= prim.last ? '0 : r_idx + crz_pkg::IDX_W'(1);
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output word.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= prim;
        end
    end

endmodule

// ===== rtl/core/circle_rasterizer_core.sv =====
// Circle rasterizer core: input stream of commands, output stream of spans.
// Input word (s_axis): tuser = command (0 start, 1 step); tdata = center_x,
// center_y, radius. A start loads a circle and yields no output; each step
// yields eight one-pixel spans in outline mode or four spans in fill mode,
// tlast on the final word of the step, and circle_done on every word of the
// step that finishes the circle. A step with no circle loaded yields one
// word with primitive_valid low, tlast and circle_done high.
// The cfg channel writes fill_mode; it is always ready.
// A step is written into the step queue, and its words then into the output register.
// The output register delivers one word per cycle while m_axis_tready is high;
// commands are taken one per cycle until the step queue is full.
// Reset clears the circle state, fill_mode, the queue and the output.
// When m_axis_tready is low the output word holds, the queue fills, and
// s_axis_tready drops once the queue holds QUEUE_DEPTH steps.
// Depends on crz_pkg, crz_front, crz_queue, crz_back and assert_macros.svh.
`include "assert_macros.svh"

module circle_rasterizer_core #(
    parameter int QUEUE_DEPTH = crz_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // center_x [14:0], center_y [29:15], radius [43:30], zero fill [47:44]
    input  logic [47:0] s_axis_tdata,
    // command [0]
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // x_start [15:0], x_end [31:16], row_y [47:32]
    output logic [47:0] m_axis_tdata,
    // primitive_valid [0], circle_done [1]
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_data
);

    logic           w_push;
    logic           w_pop;
    logic           w_q_valid;
    logic           w_q_full;
    crz_pkg::t_step w_entry;
    crz_pkg::t_step w_head;
    crz_pkg::t_prim w_out;

    assign o_cfg_ready = 1'b1;

    // Command intake and circle state.
    crz_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_fill (i_cfg_data[0]),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_command  (s_axis_tuser[0]),
        .i_center_x (s_axis_tdata[14:0]),
        .i_center_y (s_axis_tdata[29:15]),
        .i_radius   (s_axis_tdata[43:30]),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_entry    (w_entry)
    );

    // Step queue.
    crz_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_entry(w_entry),
        .i_pop  (w_pop),
        .o_head (w_head),
        .o_valid(w_q_valid),
        .o_full (w_q_full)
    );

    // Primitive emission.
    crz_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_head_valid(w_q_valid),
        .o_pop       (w_pop),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out       (w_out)
    );

    // Output packing.
    assign m_axis_tdata = {w_out.row_y, w_out.x_end, w_out.x_start};
    assign m_axis_tuser = {w_out.done, w_out.prim_valid};
    assign m_axis_tlast = w_out.last;

    // A word without a primitive is always the only, final word of its step.
    `CRZ_ASSERT_IMPLY(a_idle_word, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser[0], m_axis_tlast && m_axis_tuser[1], "idle word lacks tlast or circle_done")
    // Retiring a step leaves its final word in the output register.
    `CRZ_ASSERT_NEXT(a_pop_last, i_clk, i_rst_n, w_pop, m_axis_tvalid && m_axis_tlast, "step retired without its final word")
    // With the queue empty, a taken or empty output stays empty.
    `CRZ_ASSERT_NEXT(a_no_phantom, i_clk, i_rst_n, !w_q_valid && !(m_axis_tvalid && !m_axis_tready), !m_axis_tvalid, "output word appeared with no queued step")

endmodule

// ===== verif/circle_rasterizer_core_tb.sv =====
// Self-checking testbench for circle_rasterizer_core: drives command words, predicts the spans.
// Depends on crz_pkg and the circle_rasterizer_core RTL; needs no other files.
module circle_rasterizer_core_tb;
    import crz_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_WAIT  = 16;
    localparam int RX_HOLD_LEN  = 300;
    localparam int IDLE_PERCENT = 31;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic [0:0]  s_axis_tuser = CMD_START;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_data = 1'b0;

    // Predicted circle state, mirroring the block.
    logic signed [14:0] circ_cx;
    logic signed [14:0] circ_cy;
    logic        [13:0] circ_r;
    logic        [14:0] off_col;
    logic signed [14:0] off_row;
    logic signed [16:0] decision;
    bit                 circ_active;
    bit                 fill_mode_q;

    t_prim expected_spans[$];
    int    err_count = 0;
    int    items_sent = 0;
    int    cycle_count = 0;

    // Traffic shaping shared between the test tasks and the receiver.
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    int rx_hold_req = 0;
    int rx_hold_seen = 0;
    int rx_hold_left = 0;

    circle_rasterizer_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 0;
    end

    // Queues one predicted span or point.
    task automatic push_span(input int xs, input int xe, input int y, input bit valid,
                             input bit last, input bit done_f);
        t_prim p;
        p.x_start    = xs[15:0];
        p.x_end      = xe[15:0];
        p.row_y      = y[15:0];
        p.prim_valid = valid;
        p.last       = last;
        p.done       = done_f;
        expected_spans.push_back(p);
    endtask

    // Applies one accepted command word to the predicted state and queues its spans.
    task automatic rasterize_cmd(input logic cmd, input logic [47:0] data);
        int cx, cy, ox, oy, r, d, a, b;
        int xs[8];
        int xe[8];
        int ry[8];
        int n;
        bit done_f;
        if (cmd == CMD_START) begin
            circ_cx     = data[14:0];
            circ_cy     = data[29:15];
            circ_r      = data[43:30];
            off_col     = '0;
            off_row     = circ_r;
            r           = circ_r;
            d           = r - 1;
            decision    = d[16:0];
            circ_active = 1'b1;
        end else if (!circ_active) begin
            push_span(0, 0, 0, 1'b0, 1'b1, 1'b1);
        end else begin
            cx = circ_cx;
            cy = circ_cy;
            ox = off_col;
            oy = off_row;
            r  = circ_r;
            if (!fill_mode_q) begin
                xs[0] = cx + ox; ry[0] = cy + oy;
                xs[1] = cx + oy; ry[1] = cy + ox;
                xs[2] = cx - ox; ry[2] = cy + oy;
                xs[3] = cx - oy; ry[3] = cy + ox;
                xs[4] = cx + ox; ry[4] = cy - oy;
                xs[5] = cx + oy; ry[5] = cy - ox;
                xs[6] = cx - ox; ry[6] = cy - oy;
                xs[7] = cx - oy; ry[7] = cy - ox;
                for (int k = 0; k < 8; k++) xe[k] = xs[k];
                n = 8;
            end else begin
                xs[0] = cx - oy; xe[0] = cx + oy; ry[0] = cy + ox;
                xs[1] = cx - ox; xe[1] = cx + ox; ry[1] = cy + oy;
                xs[2] = cx - ox; xe[2] = cx + ox; ry[2] = cy - oy;
                xs[3] = cx - oy; xe[3] = cx + oy; ry[3] = cy - ox;
                n = 4;
            end
            // Andres update: move right, move down, or move diagonally.
            d = decision;
            if (d >= 2 * ox) begin
                d = d - (2 * ox + 1);
                ox++;
            end else if (d < 2 * (r - oy)) begin
                d = d + 2 * oy - 1;
                oy--;
            end else begin
                d = d + 2 * (oy - ox - 1);
                oy--;
                ox++;
            end
            decision    = d[16:0];
            off_col     = ox[14:0];
            off_row     = oy[14:0];
            a           = off_row;
            b           = off_col;
            circ_active = (a >= b);
            done_f      = !circ_active;
            for (int k = 0; k < n; k++)
                push_span(xs[k], xe[k], ry[k], 1'b1, k == n - 1, done_f);
        end
    endtask

    // Offers one command word and returns in the cycle it is taken; tvalid stays high.
    task automatic send_cmd(input logic cmd, input logic [47:0] data);
        if (!tx_steady && $urandom_range(99) < IDLE_PERCENT) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < IDLE_PERCENT);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= data;
        do @(posedge i_clk); while (!s_axis_tready);
        rasterize_cmd(cmd, data);
        items_sent++;
    endtask

    task automatic send_start(input int cx, input int cy, input int r);
        logic [47:0] w;
        w = {4'b0, r[13:0], cy[14:0], cx[14:0]};
        send_cmd(CMD_START, w);
    endtask

    // Step words carry random payload, which the block ignores.
    task automatic send_step();
        logic [47:0] w;
        w = {4'b0, 12'($urandom), $urandom};
        send_cmd(CMD_STEP, w);
    endtask

    // Steps the loaded circle to its end, or at most max_steps times.
    task automatic run_circle(input int max_steps);
        int cnt;
        cnt = 0;
        while (circ_active && cnt < max_steps) begin
            send_step();
            cnt++;
        end
    endtask

    // Stops offering words, waits for every predicted span, then lets the pipe settle.
    task automatic wait_until_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_spans.size() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_fill_mode(input bit v);
        wait_until_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        fill_mode_q = v;
    endtask

    // A step with no circle loaded, straight after reset.
    task automatic test_idle_after_reset();
        send_step();
    endtask

    // Outline points at the coordinate extremes, zero radius and restart mid-circle.
    task automatic test_outline_extremes();
        write_fill_mode(1'b0);
        send_start(16383, -16384, 0);
        send_step();
        send_step();
        send_start(-16384, 16383, 16383);
        run_circle(3);
        send_start(0, 0, 5);
        run_circle(1000);
        send_step();
    endtask

    // Filled spans at the extremes, and a mode change in the middle of a circle.
    task automatic test_fill_spans();
        write_fill_mode(1'b1);
        send_start(-16384, -16384, 16383);
        run_circle(2);
        send_start(16383, 16383, 16383);
        run_circle(2);
        send_start(-7, 11, 6);
        run_circle(2);
        write_fill_mode(1'b0);
        run_circle(2);
        write_fill_mode(1'b1);
        run_circle(1000);
        send_step();
    endtask

    // The receiver stalls for a long stretch so the step queue fills and the input stalls.
    task automatic test_output_stall();
        wait_until_drained();
        rx_hold_req <= rx_hold_req + 1;
        tx_steady = 1'b1;
        send_start($urandom_range(32767) - 16384, $urandom_range(32767) - 16384, 12);
        run_circle(1000);
        tx_steady = 1'b0;
        wait_until_drained();
    endtask

    // Back-to-back traffic on both sides.
    task automatic test_steady_stream();
        tx_steady = 1'b1;
        rx_steady <= 1'b1;
        send_start(100, -100, 20);
        run_circle(1000);
        tx_steady = 1'b0;
        wait_until_drained();
        rx_steady <= 1'b0;
    endtask

    // Random circles, mostly stepped to completion, some abandoned, with stray steps.
    task automatic test_random_circles(input int budget);
        int sel, r, cap, phase_end;
        for (int p = 0; p < 3; p++) begin
            write_fill_mode(p == 2 ? bit'($urandom_range(1)) : bit'(p));
            phase_end = items_sent + budget / 3;
            while (items_sent < phase_end) begin
                if ($urandom_range(99) < 10) send_step();
                sel = $urandom_range(99);
                if (sel < 80) begin
                    r   = $urandom_range(24);
                    cap = 1000;
                end else if (sel < 93) begin
                    r   = $urandom_range(200, 25);
                    cap = $urandom_range(6, 1);
                end else begin
                    r   = $urandom_range(16383);
                    cap = $urandom_range(4);
                end
                send_start($urandom_range(32767), $urandom_range(32767), r);
                run_circle(cap);
                if ($urandom_range(99) < 20) send_step();
            end
        end
    endtask

    // Receiver: random stalls, steady stretches, and a counted long hold-off.
    always @(posedge i_clk) begin
        if (rx_hold_req != rx_hold_seen) begin
            rx_hold_seen  <= rx_hold_req;
            rx_hold_left  <= RX_HOLD_LEN;
            m_axis_tready <= 1'b0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left  <= rx_hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_steady) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    function automatic void check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            err_count++;
        end
    endfunction

    // Each taken output word is compared with the oldest predicted span.
    always @(posedge i_clk) begin
        t_prim want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_spans.size() == 0) begin
                $display("%0t: unexpected output word, actual data %h user %b last %b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                err_count++;
            end else begin
                want = expected_spans.pop_front();
                check_field("x_start", want.x_start, $signed(m_axis_tdata[15:0]));
                check_field("x_end", want.x_end, $signed(m_axis_tdata[31:16]));
                check_field("row_y", want.row_y, $signed(m_axis_tdata[47:32]));
                check_field("primitive_valid", want.prim_valid, m_axis_tuser[0]);
                check_field("last_of_step", want.last, m_axis_tlast);
                check_field("circle_done", want.done, m_axis_tuser[1]);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("circle_rasterizer_core_tb: done, errors");
            $finish;
        end
    end

    initial begin
        circ_cx     = '0;
        circ_cy     = '0;
        circ_r      = '0;
        off_col     = '0;
        off_row     = '0;
        decision    = '0;
        circ_active = 1'b0;
        fill_mode_q = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_after_reset();
        test_outline_extremes();
        test_fill_spans();
        test_output_stall();
        test_steady_stream();
        test_random_circles(56);

        wait_until_drained();
        if (expected_spans.size() != 0) begin
            $display("%0t: %0d predicted spans never arrived", $time, expected_spans.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("circle_rasterizer_core_tb: done, clean");
        end else begin
            $display("circle_rasterizer_core_tb: done, errors");
        end
        $finish;
    end

endmodule
